/* src/mfgb_pkg.sv */
// Shared types, codes and constants of the monochrome frame store glyph blitter.
`timescale 1ns / 1ps

package mfgb_pkg;

  localparam int FRAME_BYTES_DEF = 65536;

  // Glyph coordinates span -255 .. 1278, so 12 bits two's complement.
  localparam int COORD_W   = 12;
  // Byte index before the store bound check: 11-bit row times 8-bit pitch plus column byte.
  localparam int IDX_W     = 20;
  localparam int CFG_IDX_W = 4;
  localparam int DIM_W     = 11;

  localparam logic [2:0] OP_SET_PIXEL  = 3'd0;
  localparam logic [2:0] OP_FILL       = 3'd1;
  localparam logic [2:0] OP_START      = 3'd2;
  localparam logic [2:0] OP_GLYPH_BYTE = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] ORIENT_NORMAL  = 2'd0;
  localparam logic [1:0] ORIENT_ROT_DEC = 2'd1;
  localparam logic [1:0] ORIENT_ROT_INC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd800;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [7:0] MSB_MASK   = 8'h80;
  localparam logic [2:0] LAST_BIT   = 3'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic        color;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [1:0]  orientation;
    logic [7:0]  glyph_bits;
    logic [15:0] address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     value;
  } cfg_write_t;

  typedef struct packed {
    logic             drop;
    logic [IDX_W-1:0] idx;
    logic [7:0]       mask;
  } pix_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_MUL,
    ST_PIX_IDX,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FILL_MUL,
    ST_FILL_IDX,
    ST_FILL_CLAMP,
    ST_FILL_RUN,
    ST_RD_BYTE,
    ST_DONE
  } state_t;

endpackage

/* src/mfgb_stream_if.sv */
// Valid/ready channel carrying one payload item per request.
`timescale 1ns / 1ps

interface mfgb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/mfgb_frame_store.sv */
// Single-port byte frame store with registered read data.
`timescale 1ns / 1ps

module mfgb_frame_store #(
  parameter int FRAME_BYTES = mfgb_pkg::FRAME_BYTES_DEF,
  localparam int ADDR_W = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wr_data,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/mfgb_pixel_addr.sv */
// Two-stage pixel address unit: bounds test, row multiply, byte index and bit mask.
`timescale 1ns / 1ps

module mfgb_pixel_addr #(
  parameter int FRAME_BYTES = mfgb_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic [mfgb_pkg::COORD_W-1:0] x,
  input  logic [mfgb_pkg::COORD_W-1:0] y,
  input  logic [mfgb_pkg::DIM_W-1:0]   frame_width,
  input  logic [mfgb_pkg::DIM_W-1:0]   frame_height,
  output mfgb_pkg::pix_addr_t          res
);

  localparam int PROD_W = mfgb_pkg::DIM_W + 8;

  logic [7:0]                  row_bytes;
  logic [PROD_W-1:0]           prod_r;
  logic [7:0]                  xbyte_r;
  logic [2:0]                  bit_r;
  logic                        bad_r;
  logic [mfgb_pkg::IDX_W-1:0]  sum;
  mfgb_pkg::pix_addr_t         res_r;

  assign row_bytes = frame_width[10:3];

  // Stage one: the sign bits mark coordinates left of or above the frame.
  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(y[10:0]) * PROD_W'(row_bytes);
    xbyte_r <= x[10:3];
    bit_r   <= x[2:0];
    bad_r   <= x[11] || y[11] || (x[10:3] >= row_bytes) || (y[10:0] >= frame_height);
  end

  assign sum = mfgb_pkg::IDX_W'(prod_r) + mfgb_pkg::IDX_W'(xbyte_r);

  always_ff @(posedge clk) begin
    res_r.idx  <= sum;
    res_r.drop <= bad_r || (sum >= mfgb_pkg::IDX_W'(FRAME_BYTES));
    res_r.mask <= mfgb_pkg::MSB_MASK >> bit_r;
  end

  assign res = res_r;

endmodule

/* src/mono_framebuffer_glyph_blit_top.sv */
// Top level: sequencer, glyph cursor and configuration of the glyph blitter.
//
// Channels: in_ch takes one request per item (set pixel, fill, start glyph,
// glyph bitmap byte, read byte); out_ch returns exactly one result per
// request; cfg_ch writes frame_width (index 0) and frame_height (index 1) and
// is always ready. All three are valid/ready handshakes.
// Every pixel goes through the one shared address unit and the single store
// port: multiply, index, read, write; a dropped pixel skips the write.
// Set pixel runs these steps once, glyph byte once per bitmap bit (at most
// eight; none if no glyph pixels are left); start glyph and unknown operations
// skip them; read byte reads one byte if its address is in range; fill takes
// multiply, index and clamp steps, then writes frame_height * (frame_width / 8)
// bytes, that length capped at FRAME_BYTES. One request is in work at a time;
// in_ch.ready is high only while idle, so the next request waits for the last.
// A finished result waits in the output register while the next request is
// taken; a request finishing before that register drains holds until it does.
// Reset (rst_n low, synchronous) clears the sequencer, the glyph state and the
// result valid flag and restores 800 by 480. The store is not cleared; read it
// only where a fill or pixel write has gone before.
`timescale 1ns / 1ps

module mono_framebuffer_glyph_blit_top #(
  parameter int FRAME_BYTES = mfgb_pkg::FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mfgb_stream_if.sink   in_ch,
  mfgb_stream_if.source out_ch,
  mfgb_stream_if.sink   cfg_ch
);

  localparam int ADDR_W  = $clog2(FRAME_BYTES);
  localparam int IDX_W   = mfgb_pkg::IDX_W;
  localparam int COORD_W = mfgb_pkg::COORD_W;
  localparam logic [IDX_W-1:0] STORE_LIMIT = IDX_W'(FRAME_BYTES);

  mfgb_pkg::state_t state_r, state_nxt;

  mfgb_pkg::in_item_t in_item;
  mfgb_pkg::cfg_write_t cfg_item;
  mfgb_pkg::pix_addr_t pa;

  logic [mfgb_pkg::DIM_W-1:0] frame_width_r, frame_height_r;

  logic [9:0]  origin_x_r, origin_y_r;
  logic [7:0]  cur_gw_r;
  logic [15:0] pixels_left_r;
  logic [7:0]  cursor_col_r, cursor_row_r;
  logic [1:0]  cur_orient_r;
  logic [2:0]  bit_cnt_r;

  logic [2:0]  op_r;
  logic [9:0]  pos_x_r, pos_y_r;
  logic        color_r;
  logic [7:0]  bits_r;
  logic [IDX_W-1:0] addr_r;
  logic        res_drop_r;
  logic [IDX_W-1:0] fill_total_r, fill_cnt_r;

  logic        out_valid_r;
  mfgb_pkg::out_item_t out_item_r;

  logic        in_ready, in_fire, out_free, pixel_done, last_pixel, fill_active;
  logic        addr_ok, pix_white;
  logic [COORD_W-1:0] pix_x, pix_y;

  logic              mem_rd_en, mem_wr_en;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wr_data, mem_rd_data;

  assign in_item  = in_ch.data;
  assign cfg_item = cfg_ch.data;
  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign pixel_done  = ((state_r == mfgb_pkg::ST_PIX_RD) && pa.drop) ||
                       (state_r == mfgb_pkg::ST_PIX_WR);
  assign last_pixel  = (op_r != mfgb_pkg::OP_GLYPH_BYTE) ||
                       (bit_cnt_r == mfgb_pkg::LAST_BIT) || (pixels_left_r == 16'd1);
  assign fill_active = fill_cnt_r != fill_total_r;
  assign addr_ok     = addr_r < STORE_LIMIT;
  assign pix_white   = (op_r == mfgb_pkg::OP_SET_PIXEL) ? color_r : !bits_r[7];

  // Operand selection for the shared address unit.
  always_comb begin
    pix_x = COORD_W'(cursor_col_r) + COORD_W'(origin_x_r);
    pix_y = COORD_W'(origin_y_r) + COORD_W'(cursor_row_r);
    priority if (op_r == mfgb_pkg::OP_SET_PIXEL) begin
      pix_x = COORD_W'(pos_x_r);
      pix_y = COORD_W'(pos_y_r);
    end else if (op_r == mfgb_pkg::OP_FILL) begin
      pix_x = '0;
      pix_y = COORD_W'(frame_height_r);
    end else if (cur_orient_r == mfgb_pkg::ORIENT_ROT_DEC) begin
      pix_x = COORD_W'(origin_x_r) + COORD_W'(cursor_row_r);
      pix_y = COORD_W'(origin_y_r) - COORD_W'(cursor_col_r);
    end else if (cur_orient_r == mfgb_pkg::ORIENT_ROT_INC) begin
      pix_x = COORD_W'(origin_x_r) + COORD_W'(cursor_row_r);
      pix_y = COORD_W'(origin_y_r) + COORD_W'(cursor_col_r);
    end
  end

  mfgb_pixel_addr #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_pixel_addr (
    .clk         (clk),
    .x           (pix_x),
    .y           (pix_y),
    .frame_width (frame_width_r),
    .frame_height(frame_height_r),
    .res         (pa)
  );

  mfgb_frame_store #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame_store (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .wr_en  (mem_wr_en),
    .addr   (mem_addr),
    .wr_data(mem_wr_data),
    .rd_data(mem_rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfgb_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item.operation)
            mfgb_pkg::OP_SET_PIXEL:  state_nxt = mfgb_pkg::ST_PIX_MUL;
            mfgb_pkg::OP_FILL:       state_nxt = mfgb_pkg::ST_FILL_MUL;
            mfgb_pkg::OP_GLYPH_BYTE: state_nxt = (pixels_left_r != 16'd0) ?
                                                 mfgb_pkg::ST_PIX_MUL : mfgb_pkg::ST_DONE;
            mfgb_pkg::OP_READ:       state_nxt = mfgb_pkg::ST_RD_BYTE;
            default:                 state_nxt = mfgb_pkg::ST_DONE;
          endcase
        end
      end
      mfgb_pkg::ST_PIX_MUL: state_nxt = mfgb_pkg::ST_PIX_IDX;
      mfgb_pkg::ST_PIX_IDX: state_nxt = mfgb_pkg::ST_PIX_RD;
      mfgb_pkg::ST_PIX_RD: begin
        if (!pa.drop) begin
          state_nxt = mfgb_pkg::ST_PIX_WR;
        end else begin
          state_nxt = last_pixel ? mfgb_pkg::ST_DONE : mfgb_pkg::ST_PIX_MUL;
        end
      end
      mfgb_pkg::ST_PIX_WR:
        state_nxt = last_pixel ? mfgb_pkg::ST_DONE : mfgb_pkg::ST_PIX_MUL;
      mfgb_pkg::ST_FILL_MUL:   state_nxt = mfgb_pkg::ST_FILL_IDX;
      mfgb_pkg::ST_FILL_IDX:   state_nxt = mfgb_pkg::ST_FILL_CLAMP;
      mfgb_pkg::ST_FILL_CLAMP: state_nxt = mfgb_pkg::ST_FILL_RUN;
      mfgb_pkg::ST_FILL_RUN: begin
        if (!fill_active) begin
          state_nxt = mfgb_pkg::ST_DONE;
        end
      end
      mfgb_pkg::ST_RD_BYTE: state_nxt = mfgb_pkg::ST_DONE;
      mfgb_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mfgb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mfgb_pkg::ST_IDLE;
    endcase
  end

  // Handshake and store port controls.
  always_comb begin
    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_addr    = pa.idx[ADDR_W-1:0];
    mem_wr_data = pix_white ? (mem_rd_data | pa.mask) : (mem_rd_data & ~pa.mask);
    unique case (state_r)
      mfgb_pkg::ST_IDLE: in_ready = 1'b1;
      mfgb_pkg::ST_PIX_RD: mem_rd_en = !pa.drop;
      mfgb_pkg::ST_PIX_WR: mem_wr_en = 1'b1;
      mfgb_pkg::ST_FILL_RUN: begin
        mem_wr_en   = fill_active;
        mem_addr    = fill_cnt_r[ADDR_W-1:0];
        mem_wr_data = color_r ? mfgb_pkg::BYTE_WHITE : mfgb_pkg::BYTE_BLACK;
      end
      mfgb_pkg::ST_RD_BYTE: begin
        mem_rd_en = addr_ok;
        mem_addr  = addr_r[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // Control state, glyph cursor and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mfgb_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      frame_width_r  <= mfgb_pkg::FRAME_WIDTH_RST;
      frame_height_r <= mfgb_pkg::FRAME_HEIGHT_RST;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      cur_gw_r       <= '0;
      pixels_left_r  <= '0;
      cursor_col_r   <= '0;
      cursor_row_r   <= '0;
      cur_orient_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        if (cfg_item.index == mfgb_pkg::REG_FRAME_WIDTH) begin
          frame_width_r <= cfg_item.value;
        end else if (cfg_item.index == mfgb_pkg::REG_FRAME_HEIGHT) begin
          frame_height_r <= cfg_item.value;
        end
      end
      if (in_fire && (in_item.operation == mfgb_pkg::OP_START)) begin
        origin_x_r    <= in_item.pos_x;
        origin_y_r    <= in_item.pos_y;
        cur_gw_r      <= in_item.glyph_width;
        pixels_left_r <= 16'(in_item.glyph_width) * 16'(in_item.glyph_height);
        cursor_col_r  <= '0;
        cursor_row_r  <= '0;
        cur_orient_r  <= in_item.orientation;
      end
      if (pixel_done && (op_r == mfgb_pkg::OP_GLYPH_BYTE)) begin
        pixels_left_r <= pixels_left_r - 16'd1;
        if (cursor_col_r + 8'd1 >= cur_gw_r) begin
          cursor_col_r <= '0;
          cursor_row_r <= cursor_row_r + 8'd1;
        end else begin
          cursor_col_r <= cursor_col_r + 8'd1;
        end
      end
      if ((state_r == mfgb_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload, fill counter and result value.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_item.operation;
      pos_x_r    <= in_item.pos_x;
      pos_y_r    <= in_item.pos_y;
      color_r    <= in_item.color;
      bits_r     <= in_item.glyph_bits;
      addr_r     <= IDX_W'(in_item.address);
      bit_cnt_r  <= '0;
      res_drop_r <= 1'b0;
    end
    if (pixel_done) begin
      bits_r    <= {bits_r[6:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + 3'd1;
      if (pa.drop) begin
        res_drop_r <= 1'b1;
      end
    end
    // The address unit's raw sum here is frame_height * bytes per row.
    if (state_r == mfgb_pkg::ST_FILL_CLAMP) begin
      fill_cnt_r <= '0;
      if (pa.idx > STORE_LIMIT) begin
        fill_total_r <= STORE_LIMIT;
        res_drop_r   <= 1'b1;
      end else begin
        fill_total_r <= pa.idx;
      end
    end
    if ((state_r == mfgb_pkg::ST_FILL_RUN) && fill_active) begin
      fill_cnt_r <= fill_cnt_r + IDX_W'(1);
    end
    if ((state_r == mfgb_pkg::ST_RD_BYTE) && !addr_ok) begin
      res_drop_r <= 1'b1;
    end
    if ((state_r == mfgb_pkg::ST_DONE) && out_free) begin
      out_item_r.out_of_range <= res_drop_r;
      out_item_r.read_data    <= ((op_r == mfgb_pkg::OP_READ) && !res_drop_r) ?
                                 mem_rd_data : 8'd0;
    end
  end

  a_fill_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfgb_pkg::ST_FILL_RUN) |-> (fill_cnt_r <= fill_total_r))
    else $error("fill counter ran past the fill length");

  a_fill_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfgb_pkg::ST_FILL_RUN) |-> (fill_total_r <= STORE_LIMIT))
    else $error("fill length exceeds the store");

  a_pixel_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfgb_pkg::ST_PIX_WR) |-> (!pa.drop && (pa.idx < STORE_LIMIT)))
    else $error("pixel write outside the frame store");

  a_cursor_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (pixels_left_r != 16'd0) |-> (cursor_col_r < cur_gw_r))
    else $error("glyph cursor column beyond glyph width");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == mfgb_pkg::ST_DONE))
    else $error("result produced outside the completion state");

endmodule
